// ===== hw/rtl/gbwfc_pkg.sv =====
package gbwfc_pkg;

  // Fixed field widths
  localparam int PW_W    = 13;
  localparam int POS_W   = 12;
  localparam int DIM_W   = 13;
  localparam int COORD_W = 15;
  localparam int ADDR_W  = 26;
  localparam int DATA_W  = 32;
  localparam int WSUM_W  = 24;
  localparam int LUM_W   = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Command queue depth
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Q16 luminance weights
  localparam logic [15:0] LUMA_WR = 16'd19595;
  localparam logic [15:0] LUMA_WG = 16'd38470;
  localparam logic [15:0] LUMA_WB = 16'd7471;

  // Input action codes
  localparam logic ACT_FILL = 1'b0;
  localparam logic ACT_COPY = 1'b1;

  // Format modes: bit0 source is RGBA, bit1 atlas is RGBA
  localparam logic [1:0] FMT_GRAY_GRAY = 2'd0;
  localparam logic [1:0] FMT_RGBA_GRAY = 2'd1;
  localparam logic [1:0] FMT_GRAY_RGBA = 2'd2;
  localparam logic [1:0] FMT_RGBA_RGBA = 2'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGE_WIDTH  = 3'd0,
    REG_DEST_X      = 3'd1,
    REG_DEST_Y      = 3'd2,
    REG_DEST_W      = 3'd3,
    REG_DEST_H      = 3'd4,
    REG_SRC_W       = 3'd5,
    REG_SRC_H       = 3'd6,
    REG_FORMAT_MODE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [PW_W-1:0]  page_width;
    logic [POS_W-1:0] dest_x;
    logic [POS_W-1:0] dest_y;
    logic [DIM_W-1:0] dest_w;
    logic [DIM_W-1:0] dest_h;
    logic [DIM_W-1:0] src_w;
    logic [DIM_W-1:0] src_h;
    logic [1:0]       format_mode;
  } cfg_t;

  // One classified write, front to back
  typedef struct packed {
    logic               op;
    logic               last;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } cmd_t;

endpackage

// ===== hw/rtl/gbwfc_front.sv =====
module gbwfc_front
  import gbwfc_pkg::*;
#(
  parameter int MAX_PAGE_DIM = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  input  logic       in_action,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  input  logic       q_full,
  output logic       in_stall,
  output logic       push,
  output cmd_t       cmd
);

  localparam int CLAMP_DIM = (MAX_PAGE_DIM > 8191) ? 8191 : MAX_PAGE_DIM;
  localparam int CUR_W     = $clog2(CLAMP_DIM);
  localparam int CNT_W     = CUR_W + 1;

  function automatic logic [DIM_W-1:0] clampdim(input logic [DIM_W-1:0] v);
    clampdim = (v > DIM_W'(CLAMP_DIM)) ? DIM_W'(CLAMP_DIM) : v;
  endfunction

  logic [CUR_W-1:0] fcol_r, frow_r, ccol_r, crow_r;
  logic [CUR_W-1:0] fcol_nxt, frow_nxt, ccol_nxt, crow_nxt;
  logic [DIM_W-1:0] dw, dh, sw, sh, ox, oy;
  logic [DIM_W-1:0] cur_w, cur_h;
  logic [CUR_W-1:0] cur_col, cur_row, new_col, new_row;
  logic [CNT_W-1:0] col_inc, row_inc;
  logic             is_copy, drop, accept, row_end, pass_end;

  assign dw = clampdim(cfg.dest_w);
  assign dh = clampdim(cfg.dest_h);
  assign sw = clampdim(cfg.src_w);
  assign sh = clampdim(cfg.src_h);

  // Centering offsets, zero when the cell is smaller than the glyph
  assign ox = (dw >= sw) ? ((dw - sw) >> 1) : '0;
  assign oy = (dh >= sh) ? ((dh - sh) >> 1) : '0;

  assign is_copy  = (in_action == ACT_COPY);
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign drop     = (sw == '0) || (sh == '0) ||
                    (!is_copy && ((dw == '0) || (dh == '0)));
  assign push     = accept && !drop;

  // Select the cursor that this transaction walks
  assign cur_col = is_copy ? ccol_r : fcol_r;
  assign cur_row = is_copy ? crow_r : frow_r;
  assign cur_w   = is_copy ? sw : dw;
  assign cur_h   = is_copy ? sh : dh;

  assign col_inc  = CNT_W'(cur_col) + CNT_W'(1);
  assign row_inc  = CNT_W'(cur_row) + CNT_W'(1);
  assign row_end  = col_inc >= CNT_W'(cur_w);
  assign pass_end = row_end && (row_inc >= CNT_W'(cur_h));

  // Advance row-major, wrap to the origin after the last pixel
  always_comb begin
    new_col = row_end ? '0 : col_inc[CUR_W-1:0];
    new_row = cur_row;
    if (row_end) begin
      new_row = pass_end ? '0 : row_inc[CUR_W-1:0];
    end
    fcol_nxt = fcol_r;
    frow_nxt = frow_r;
    ccol_nxt = ccol_r;
    crow_nxt = crow_r;
    if (push) begin
      if (is_copy) begin
        ccol_nxt = new_col;
        crow_nxt = new_row;
      end else begin
        fcol_nxt = new_col;
        frow_nxt = new_row;
      end
    end
  end

  // Build the command
  always_comb begin
    cmd.op    = in_action;
    cmd.last  = pass_end;
    cmd.red   = in_red;
    cmd.green = in_green;
    cmd.blue  = in_blue;
    cmd.alpha = in_alpha;
    if (is_copy) begin
      cmd.x = COORD_W'(cfg.dest_x) + COORD_W'(ox) + COORD_W'(cur_col);
      cmd.y = COORD_W'(cfg.dest_y) + COORD_W'(oy) + COORD_W'(cur_row);
    end else begin
      cmd.x = COORD_W'(cfg.dest_x) + COORD_W'(cur_col);
      cmd.y = COORD_W'(cfg.dest_y) + COORD_W'(cur_row);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fcol_r <= '0;
      frow_r <= '0;
      ccol_r <= '0;
      crow_r <= '0;
    end else begin
      fcol_r <= fcol_nxt;
      frow_r <= frow_nxt;
      ccol_r <= ccol_nxt;
      crow_r <= crow_nxt;
    end
  end

endmodule

// ===== hw/rtl/gbwfc_fifo.sv =====
module gbwfc_fifo
  import gbwfc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic not_empty,
  output cmd_t pop_cmd
);

  cmd_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push, do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_cmd   = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Store incoming commands
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  // Move pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

endmodule

// ===== hw/rtl/gbwfc_back.sv =====
module gbwfc_back
  import gbwfc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [PW_W-1:0]   page_width,
  input  logic [1:0]        format_mode,
  input  logic              q_not_empty,
  input  cmd_t              q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] out_write_address,
  output logic [DATA_W-1:0] out_write_data,
  output logic              out_write_wide,
  output logic              out_last
);

  typedef struct packed {
    logic               op;
    logic               last;
    logic [COORD_W-1:0] x;
    logic [ADDR_W-1:0]  row_base;
    logic [WSUM_W-1:0]  wsum;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } s1_t;

  typedef struct packed {
    logic               op;
    logic               last;
    logic [ADDR_W-1:0]  pix;
    logic [LUM_W-1:0]   lum;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
  } s2_t;

  localparam int PROD_W = COORD_W + PW_W;

  s1_t               s1_r, s1_nxt;
  s2_t               s2_r, s2_nxt;
  logic              s1_v_r, s2_v_r, out_valid_r;
  logic              advance, atlas4;
  logic [PROD_W-1:0] prod_full;
  logic [15:0]       lum_hi;
  logic [15:0]       div_sum;
  logic [7:0]        luma;
  logic [ADDR_W-1:0] addr_nxt;
  logic [DATA_W-1:0] data_nxt;
  logic [ADDR_W-1:0] out_addr_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_wide_r, out_last_r;

  assign atlas4  = format_mode[1];
  assign advance = !out_valid_r || !out_stall;
  assign q_pop   = advance && q_not_empty;

  // Stage 1: row base and weighted channel sum
  assign prod_full = PROD_W'(q_cmd.y) * PROD_W'(page_width);
  always_comb begin
    s1_nxt.op       = q_cmd.op;
    s1_nxt.last     = q_cmd.last;
    s1_nxt.x        = q_cmd.x;
    s1_nxt.row_base = prod_full[ADDR_W-1:0];
    s1_nxt.wsum     = WSUM_W'(LUMA_WR) * WSUM_W'(q_cmd.red) +
                      WSUM_W'(LUMA_WG) * WSUM_W'(q_cmd.green) +
                      WSUM_W'(LUMA_WB) * WSUM_W'(q_cmd.blue);
    s1_nxt.red      = q_cmd.red;
    s1_nxt.green    = q_cmd.green;
    s1_nxt.blue     = q_cmd.blue;
    s1_nxt.alpha    = q_cmd.alpha;
  end

  // Stage 2: pixel index and alpha premultiply
  always_comb begin
    s2_nxt.op    = s1_r.op;
    s2_nxt.last  = s1_r.last;
    s2_nxt.pix   = s1_r.row_base + ADDR_W'(s1_r.x);
    s2_nxt.lum   = LUM_W'(s1_r.wsum) * LUM_W'(s1_r.alpha);
    s2_nxt.red   = s1_r.red;
    s2_nxt.green = s1_r.green;
    s2_nxt.blue  = s1_r.blue;
    s2_nxt.alpha = s1_r.alpha;
  end

  // Stage 3: divide by 255 (exact below 65280) and pack bytes
  assign lum_hi  = s2_r.lum[LUM_W-1:16];
  assign div_sum = lum_hi + (lum_hi >> 8) + 16'd1;
  assign luma    = div_sum[15:8];
  assign addr_nxt = atlas4 ? {s2_r.pix[ADDR_W-3:0], 2'b00} : s2_r.pix;

  always_comb begin
    if (s2_r.op == ACT_FILL) begin
      data_nxt = atlas4 ? 32'hFFFF_FFFF : 32'h0000_00FF;
    end else begin
      case (format_mode)
        FMT_RGBA_RGBA: data_nxt = {s2_r.alpha, s2_r.blue, s2_r.green, s2_r.red};
        FMT_GRAY_RGBA: data_nxt = {4{s2_r.red}};
        FMT_RGBA_GRAY: data_nxt = {24'd0, luma};
        FMT_GRAY_GRAY: data_nxt = {24'd0, s2_r.red};
        default:       data_nxt = {24'd0, s2_r.red};
      endcase
    end
  end

  // Hold all stages while the output transaction is stalled
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_r       <= s1_nxt;
      s2_r       <= s2_nxt;
      out_addr_r <= addr_nxt;
      out_data_r <= data_nxt;
      out_wide_r <= atlas4;
      out_last_r <= s2_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (advance) begin
      s1_v_r      <= q_not_empty;
      s2_v_r      <= s1_v_r;
      out_valid_r <= s2_v_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_address = out_addr_r;
  assign out_write_data    = out_data_r;
  assign out_write_wide    = out_wide_r;
  assign out_last          = out_last_r;

  a_out_from_s2: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_v_r))
    else $error("output valid without stage 2 data");

  a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(s1_v_r) && $stable(s2_v_r)))
    else $error("pipeline moved under output stall");

endmodule

// ===== hw/rtl/glyph_blit_with_format_convert_core.sv =====
// Glyph blit engine: each accepted transaction is either a fill tick that
// writes 255 to the next pixel of the destination cell, or one glyph pixel
// written centered in the cell, converted per format_mode. At most one
// memory write results per transaction; transactions that write nothing
// (zero glyph size, or a fill into an empty cell) are accepted and dropped.
// A front stage classifies the transaction and walks the fill and copy
// cursors, a four-entry command queue decouples it from a three-stage back
// pipeline (row multiply and channel weighting, alpha premultiply and pixel
// index, divide-by-255 and byte packing). Sustained rate is one transaction
// per cycle unless a stall holds it; out_valid rises after the queue and the
// stage 1, stage 2 and output registers. The user must write configuration
// registers only while the engine is idle; the block does not enforce this.
module glyph_blit_with_format_convert_core
  import gbwfc_pkg::*;
#(
  parameter int MAX_PAGE_DIM = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_action,
  input  logic [7:0]            in_red,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_alpha,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [ADDR_W-1:0]     out_write_address,
  output logic [DATA_W-1:0]     out_write_data,
  output logic                  out_write_wide,
  output logic                  out_last
);

  cfg_t cfg_r;
  logic push, q_full, q_not_empty, q_pop;
  cmd_t push_cmd, pop_cmd;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.page_width  <= PW_W'(4096);
      cfg_r.dest_x      <= '0;
      cfg_r.dest_y      <= '0;
      cfg_r.dest_w      <= '0;
      cfg_r.dest_h      <= '0;
      cfg_r.src_w       <= '0;
      cfg_r.src_h       <= '0;
      cfg_r.format_mode <= '0;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_PAGE_WIDTH:  cfg_r.page_width  <= cfg_data[PW_W-1:0];
        REG_DEST_X:      cfg_r.dest_x      <= cfg_data[POS_W-1:0];
        REG_DEST_Y:      cfg_r.dest_y      <= cfg_data[POS_W-1:0];
        REG_DEST_W:      cfg_r.dest_w      <= cfg_data[DIM_W-1:0];
        REG_DEST_H:      cfg_r.dest_h      <= cfg_data[DIM_W-1:0];
        REG_SRC_W:       cfg_r.src_w       <= cfg_data[DIM_W-1:0];
        REG_SRC_H:       cfg_r.src_h       <= cfg_data[DIM_W-1:0];
        REG_FORMAT_MODE: cfg_r.format_mode <= cfg_data[1:0];
        default:         cfg_r.format_mode <= cfg_r.format_mode;
      endcase
    end
  end

  gbwfc_front #(
    .MAX_PAGE_DIM(MAX_PAGE_DIM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_action(in_action),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .in_alpha (in_alpha),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .cmd      (push_cmd)
  );

  gbwfc_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .not_empty(q_not_empty),
    .pop_cmd  (pop_cmd)
  );

  gbwfc_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .page_width       (cfg_r.page_width),
    .format_mode      (cfg_r.format_mode),
    .q_not_empty      (q_not_empty),
    .q_cmd            (pop_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_write_address(out_write_address),
    .out_write_data   (out_write_data),
    .out_write_wide   (out_write_wide),
    .out_last         (out_last)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import gbwfc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_DIM       = 4096;
  localparam int unsigned IDLE_PCT      = 13;
  localparam int unsigned HOLD_CYCLES   = 120;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned TOTAL_ITEMS   = 1450;
  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned MAX_REPORTS   = 40;

  // One memory write as the engine emits it
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic              wide;
    logic              is_last;
  } atlas_write_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  in_action = ACT_FILL;
  logic [7:0]            in_red = '0;
  logic [7:0]            in_green = '0;
  logic [7:0]            in_blue = '0;
  logic [7:0]            in_alpha = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [ADDR_W-1:0]     out_write_address;
  logic [DATA_W-1:0]     out_write_data;
  logic                  out_write_wide;
  logic                  out_last;

  // Shadow of the engine: register file and the two cursors
  cfg_t        shadow;
  int unsigned fill_col, fill_row, copy_col, copy_row;
  atlas_write_t pending_writes[$];

  int unsigned cycle_count = 0;
  int unsigned accepted_count = 0;
  int unsigned predicted_count = 0;
  int unsigned checked_count = 0;
  int unsigned input_stall_cycles = 0;
  int unsigned settings_count = 0;
  int unsigned fault_count = 0;
  bit          calm = 1'b0;
  bit          hold_toggle = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;

  glyph_blit_with_format_convert_core #(
    .MAX_PAGE_DIM(MAX_DIM)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_action         (in_action),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .in_alpha          (in_alpha),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_write_wide    (out_write_wide),
    .out_last          (out_last)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: no progress, run stopped after %0d cycles", cycle_count);
      $display("glyph_blit_with_format_convert_core test failed");
      $finish;
    end
  end

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= MAX_REPORTS) begin
      $display("ERROR cycle %0d: %s", cycle_count, msg);
    end
  endtask

  function automatic int unsigned clip_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

  // Row-major cursor step; returns 1 when the pass wraps
  function automatic bit step_cursor(inout int unsigned col, inout int unsigned row,
                                     input int unsigned w, input int unsigned h);
    if (col + 1 >= w) begin
      col = 0;
      if (row + 1 >= h) begin
        row = 0;
        return 1'b1;
      end
      row = row + 1;
      return 1'b0;
    end
    col = col + 1;
    return 1'b0;
  endfunction

  function automatic logic [ADDR_W-1:0] pixel_addr(input int unsigned x, input int unsigned y,
                                                   input int unsigned bpp);
    longint unsigned p;
    p = y;
    p = (p * shadow.page_width + x) * bpp;
    return p[ADDR_W-1:0];
  endfunction

  // Work out the write one transaction causes, advancing the cursors
  function automatic bit predict_write(input logic act, input logic [7:0] r,
                                       input logic [7:0] g, input logic [7:0] b,
                                       input logic [7:0] a, output atlas_write_t w);
    int unsigned     dw, dh, sw, sh, ox, oy, bpp;
    longint unsigned wsum, lum;
    logic            atlas4;
    w = '0;
    dw = clip_dim(shadow.dest_w);
    dh = clip_dim(shadow.dest_h);
    sw = clip_dim(shadow.src_w);
    sh = clip_dim(shadow.src_h);
    atlas4 = shadow.format_mode[1];
    bpp = atlas4 ? 4 : 1;
    if (sw == 0 || sh == 0) return 1'b0;
    w.wide = atlas4;
    if (act == ACT_FILL) begin
      if (dw == 0 || dh == 0) return 1'b0;
      w.addr = pixel_addr(shadow.dest_x + fill_col, shadow.dest_y + fill_row, bpp);
      w.data = atlas4 ? 32'hFFFF_FFFF : 32'h0000_00FF;
      w.is_last = step_cursor(fill_col, fill_row, dw, dh);
    end else begin
      ox = (dw >= sw) ? (dw - sw) / 2 : 0;
      oy = (dh >= sh) ? (dh - sh) / 2 : 0;
      w.addr = pixel_addr(shadow.dest_x + ox + copy_col, shadow.dest_y + oy + copy_row, bpp);
      case (shadow.format_mode)
        FMT_RGBA_RGBA: w.data = {a, b, g, r};
        FMT_GRAY_RGBA: w.data = {4{r}};
        FMT_RGBA_GRAY: begin
          wsum = LUMA_WR * r + LUMA_WG * g + LUMA_WB * b;
          lum = wsum * a / (255 * 65536);
          w.data = (lum > 255) ? 32'd255 : 32'(lum);
        end
        default: w.data = {24'd0, r};
      endcase
      w.is_last = step_cursor(copy_col, copy_row, sw, sh);
    end
    return 1'b1;
  endfunction

  // Track register writes and accepted input, check every accepted write
  always @(posedge clk) begin : scoreboard
    atlas_write_t want, got;
    if (!rst_n) begin
      shadow = '0;
      shadow.page_width = 13'd4096;
      fill_col = 0;
      fill_row = 0;
      copy_col = 0;
      copy_row = 0;
      pending_writes.delete();
    end else begin
      if (cfg_wr_en) begin
        case (reg_idx_t'(cfg_index))
          REG_PAGE_WIDTH:  shadow.page_width = cfg_data;
          REG_DEST_X:      shadow.dest_x = cfg_data[POS_W-1:0];
          REG_DEST_Y:      shadow.dest_y = cfg_data[POS_W-1:0];
          REG_DEST_W:      shadow.dest_w = cfg_data;
          REG_DEST_H:      shadow.dest_h = cfg_data;
          REG_SRC_W:       shadow.src_w = cfg_data;
          REG_SRC_H:       shadow.src_h = cfg_data;
          REG_FORMAT_MODE: shadow.format_mode = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && in_stall) input_stall_cycles++;
      if (in_valid && !in_stall) begin
        accepted_count++;
        if (predict_write(in_action, in_red, in_green, in_blue, in_alpha, want)) begin
          pending_writes.push_back(want);
          predicted_count++;
        end
      end
      if (out_valid && !out_stall) begin
        got.addr = out_write_address;
        got.data = out_write_data;
        got.wide = out_write_wide;
        got.is_last = out_last;
        if (pending_writes.size() == 0) begin
          report_fault($sformatf("unexpected write addr 0x%07h data 0x%08h",
                                 got.addr, got.data));
        end else begin
          want = pending_writes.pop_front();
          if (got.addr !== want.addr)
            report_fault($sformatf("write %0d: address 0x%07h, expected 0x%07h",
                                   checked_count, got.addr, want.addr));
          if (got.data !== want.data)
            report_fault($sformatf("write %0d: data 0x%08h, expected 0x%08h",
                                   checked_count, got.data, want.data));
          if (got.wide !== want.wide)
            report_fault($sformatf("write %0d: wide %b, expected %b",
                                   checked_count, got.wide, want.wide));
          if (got.is_last !== want.is_last)
            report_fault($sformatf("write %0d: last %b, expected %b",
                                   checked_count, got.is_last, want.is_last));
          checked_count++;
        end
      end
    end
  end

  // Drive the write port's stall: random, long hold-off on request, none when calm
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_seen <= hold_toggle;
    end else if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic logic [7:0] rand_byte();
    int unsigned roll;
    roll = $urandom_range(15);
    if (roll == 0) return 8'h00;
    if (roll == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic rand_action();
    return ($urandom_range(1) != 0) ? ACT_COPY : ACT_FILL;
  endfunction

  function automatic cfg_t cell_cfg(input int unsigned pw, input int unsigned x,
                                    input int unsigned y, input int unsigned dw,
                                    input int unsigned dh, input int unsigned sw,
                                    input int unsigned sh, input logic [1:0] fm);
    cfg_t c;
    c.page_width = PW_W'(pw);
    c.dest_x = POS_W'(x);
    c.dest_y = POS_W'(y);
    c.dest_w = DIM_W'(dw);
    c.dest_h = DIM_W'(dh);
    c.src_w = DIM_W'(sw);
    c.src_h = DIM_W'(sh);
    c.format_mode = fm;
    return c;
  endfunction

  // Mostly small cells so passes complete; a few full-range settings
  function automatic cfg_t random_cfg();
    cfg_t        c;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) c.page_width = '0;
    else if (roll < 8) c.page_width = '1;
    else c.page_width = PW_W'($urandom_range(1, 4096));
    c.dest_x = POS_W'($urandom_range(0, 4095));
    c.dest_y = POS_W'($urandom_range(0, 4095));
    c.format_mode = 2'($urandom_range(0, 3));
    roll = $urandom_range(99);
    if (roll < 8) begin
      c.dest_w = DIM_W'($urandom_range(0, 8191));
      c.dest_h = DIM_W'($urandom_range(0, 8191));
      c.src_w = DIM_W'($urandom_range(1, 8191));
      c.src_h = DIM_W'($urandom_range(1, 8191));
    end else begin
      c.dest_w = DIM_W'($urandom_range(1, 8));
      c.dest_h = DIM_W'($urandom_range(1, 5));
      c.src_w = DIM_W'($urandom_range(1, c.dest_w + 2));
      c.src_h = DIM_W'($urandom_range(1, c.dest_h + 2));
      if (roll < 14) c.dest_w = '0;
      else if (roll < 20) c.dest_h = '0;
      else if (roll < 24) c.src_w = '0;
      else if (roll < 28) c.src_h = '0;
    end
    return c;
  endfunction

  // Offer one transaction and hold it until accepted
  task automatic send_pixel(input logic act, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
    int unsigned target;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_red <= r;
    in_green <= g;
    in_blue <= b;
    in_alpha <= a;
    target = accepted_count + 1;
    wait (accepted_count == target);
  endtask

  // Stop offering, wait for every write, then let dropped transactions clear
  task automatic drain_engine();
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Write the whole register file; engine must be idle
  task automatic program_regs(input cfg_t c);
    put_reg(REG_PAGE_WIDTH, c.page_width);
    put_reg(REG_DEST_X, c.dest_x);
    put_reg(REG_DEST_Y, c.dest_y);
    put_reg(REG_DEST_W, c.dest_w);
    put_reg(REG_DEST_H, c.dest_h);
    put_reg(REG_SRC_W, c.src_w);
    put_reg(REG_SRC_H, c.src_h);
    put_reg(REG_FORMAT_MODE, c.format_mode);
    cfg_wr_en <= 1'b0;
    settings_count++;
  endtask

  // Zero glyph width or height: nothing is written and no cursor moves
  task automatic test_zero_glyph();
    program_regs(cell_cfg(64, 3, 2, 4, 4, 0, 3, FMT_RGBA_RGBA));
    send_pixel(ACT_FILL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(ACT_COPY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    drain_engine();
    program_regs(cell_cfg(64, 3, 2, 4, 4, 3, 0, FMT_GRAY_GRAY));
    send_pixel(ACT_FILL, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(ACT_COPY, 8'hA5, 8'h5A, 8'hA5, 8'h5A);
    drain_engine();
  endtask

  // Empty cell: fills drop, copies still land (offset 0 when cell is smaller)
  task automatic test_empty_cell();
    program_regs(cell_cfg(100, 7, 9, 0, 3, 2, 1, FMT_GRAY_GRAY));
    send_pixel(ACT_FILL, 8'h11, 8'h22, 8'h33, 8'h44);
    send_pixel(ACT_COPY, 8'h80, 8'h00, 8'h00, 8'h00);
    drain_engine();
    program_regs(cell_cfg(100, 7, 9, 5, 0, 2, 1, FMT_GRAY_GRAY));
    send_pixel(ACT_FILL, 8'h11, 8'h22, 8'h33, 8'h44);
    send_pixel(ACT_COPY, 8'h7F, 8'h00, 8'h00, 8'h00);
    drain_engine();
  endtask

  // Every pixel format, narrow and wide fills, one-pixel glyph ends each pass
  task automatic test_format_modes();
    program_regs(cell_cfg(16, 5, 7, 2, 1, 1, 1, FMT_GRAY_GRAY));
    send_pixel(ACT_FILL, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(ACT_COPY, 8'h00, 8'hFF, 8'hFF, 8'hFF);
    drain_engine();
    program_regs(cell_cfg(16, 5, 7, 2, 1, 1, 1, FMT_RGBA_GRAY));
    send_pixel(ACT_COPY, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    drain_engine();
    program_regs(cell_cfg(16, 5, 7, 2, 1, 1, 1, FMT_GRAY_RGBA));
    send_pixel(ACT_COPY, 8'hFF, 8'h00, 8'h00, 8'h00);
    drain_engine();
    program_regs(cell_cfg(16, 5, 7, 2, 1, 1, 1, FMT_RGBA_RGBA));
    send_pixel(ACT_FILL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(ACT_COPY, 8'hFF, 8'h00, 8'hFF, 8'h00);
    drain_engine();
  endtask

  // Sizes above the page limit clamp; big coordinates wrap; zero pitch
  task automatic test_oversize_and_wrap();
    program_regs(cell_cfg(8191, 4095, 4095, 8191, 8191, 8191, 8191, FMT_RGBA_RGBA));
    send_pixel(ACT_FILL, 8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(ACT_COPY, 8'h12, 8'h34, 8'h56, 8'h78);
    drain_engine();
    program_regs(cell_cfg(0, 4095, 4095, 8191, 5000, 4096, 4097, FMT_GRAY_RGBA));
    send_pixel(ACT_FILL, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(ACT_COPY, 8'hC3, 8'h00, 8'h00, 8'h00);
    drain_engine();
  endtask

  // Shrink sizes below the cursors: the next transaction closes the pass
  task automatic test_cursor_shrink();
    program_regs(cell_cfg(32, 1, 1, 4, 4, 3, 3, FMT_GRAY_GRAY));
    repeat (4) send_pixel(ACT_COPY, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    repeat (2) send_pixel(ACT_FILL, rand_byte(), rand_byte(), rand_byte(), rand_byte());
    drain_engine();
    program_regs(cell_cfg(32, 1, 1, 1, 1, 1, 1, FMT_GRAY_GRAY));
    send_pixel(ACT_COPY, 8'h55, 8'hAA, 8'h55, 8'hAA);
    send_pixel(ACT_FILL, 8'hAA, 8'h55, 8'hAA, 8'h55);
    drain_engine();
  endtask

  // Hold the write port off long enough for the engine to back up
  task automatic test_output_holdoff();
    program_regs(cell_cfg(256, 10, 20, 6, 5, 4, 3, FMT_RGBA_GRAY));
    hold_toggle = !hold_toggle;
    repeat (40) send_pixel(rand_action(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
    drain_engine();
  endtask

  // Sender stops until every write is out, then resumes without reconfiguring
  task automatic test_sender_pause();
    program_regs(cell_cfg(300, 200, 100, 5, 4, 3, 2, FMT_RGBA_RGBA));
    repeat (25) send_pixel(rand_action(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
    in_valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (25) send_pixel(rand_action(), rand_byte(), rand_byte(), rand_byte(), rand_byte());
    drain_engine();
  endtask

  // Random settings; mostly whole glyph blits (fill pass then copy pass)
  task automatic test_random_glyphs();
    cfg_t        c;
    int unsigned phase_no, fills, copies, noise;
    phase_no = 0;
    while (accepted_count < TOTAL_ITEMS) begin
      c = random_cfg();
      program_regs(c);
      calm = (phase_no >= 10 && phase_no < 16);
      if ($urandom_range(99) < 70) begin
        fills = clip_dim(c.dest_w) * clip_dim(c.dest_h);
        copies = clip_dim(c.src_w) * clip_dim(c.src_h);
        if (fills > 80) fills = $urandom_range(10, 40);
        if (copies > 80) copies = $urandom_range(10, 40);
        repeat (fills) send_pixel(ACT_FILL, rand_byte(), rand_byte(), rand_byte(), rand_byte());
        repeat (copies) send_pixel(ACT_COPY, rand_byte(), rand_byte(), rand_byte(), rand_byte());
      end else begin
        noise = $urandom_range(8, 40);
        repeat (noise) send_pixel(rand_action(), rand_byte(), rand_byte(), rand_byte(),
                                  rand_byte());
      end
      drain_engine();
      phase_no++;
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_zero_glyph();
    test_empty_cell();
    test_format_modes();
    test_oversize_and_wrap();
    test_cursor_shrink();
    test_output_holdoff();
    test_sender_pause();
    test_random_glyphs();
    drain_engine();
    $display("Covered %0d transactions and %0d checked writes over %0d register settings,",
             accepted_count, checked_count, settings_count);
    $display("all four pixel formats, clamped sizes, address wrap; input stalled %0d cycles",
             input_stall_cycles);
    if (fault_count == 0) begin
      $display("glyph_blit_with_format_convert_core test passed");
    end else begin
      $display("glyph_blit_with_format_convert_core test failed");
    end
    $finish;
  end

endmodule
